>>> rtl/core/fbre_pkg.sv
`timescale 1ns / 1ps
package fbre_pkg;

   // coordinate and size widths cover the largest store (256 x 256)
   localparam int CW = 10;
   localparam int SW = 9;

   localparam logic [7:0] SPACE_CHAR = 8'h20;

   localparam logic [2:0] REQ_SET     = 3'd0;
   localparam logic [2:0] REQ_CLEAR   = 3'd1;
   localparam logic [2:0] REQ_OUTLINE = 3'd2;
   localparam logic [2:0] REQ_FILL    = 3'd3;
   localparam logic [2:0] REQ_READ    = 3'd4;

   localparam logic [1:0] CSR_ROWS    = 2'd0;
   localparam logic [1:0] CSR_COLS    = 2'd1;
   localparam logic [1:0] CSR_SYM_LO  = 2'd2;
   localparam logic [1:0] CSR_SYM_HI  = 2'd3;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_WALK,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]    op;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [SW-1:0] w;
      logic [SW-1:0] h;
      logic [7:0]    border;
      logic [7:0]    inner;
      logic [SW-1:0] act_rows;
      logic [SW-1:0] act_cols;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] cell_char;
      logic       status;
   } rsp_type;

   function automatic logic [7:0] level_char(input logic [63:0] sym_lo,
                                             input logic [63:0] sym_hi,
                                             input logic [3:0]  level);
      logic [63:0] word;
      word = level[3] ? sym_hi : sym_lo;
      return word[{level[2:0], 3'b000} +: 8];
   endfunction

endpackage

>>> rtl/core/fbre_store.sv
`timescale 1ns / 1ps
module fbre_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/fbre_seq.sv
`timescale 1ns / 1ps
module fbre_seq #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 64,
   parameter int AW       = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  fbre_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  logic             rsp_free,
   output fbre_pkg::rsp_type rsp,
   input  logic [7:0]       rd_data,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output logic [7:0]       wr_data,
   output logic             rd_en,
   output logic [AW-1:0]    rd_addr
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   fbre_pkg::state_type       state_ff, state_in;
   fbre_pkg::cmd_type         cmd_ff, cmd_in;
   logic [fbre_pkg::SW-1:0]   r_ff, r_in;
   logic [fbre_pkg::SW-1:0]   c_ff, c_in;
   logic                      clip_ff, clip_in;
   logic                      hit_ff, hit_in;
   logic [AW-1:0]             init_ff, init_in;

   logic [fbre_pkg::CW-1:0]   row;
   logic [fbre_pkg::CW-1:0]   col;
   logic [AW-1:0]             cell_addr;
   logic                      in_act;
   logic                      row_edge;
   logic                      col_last;
   logic                      fill;
   logic                      touch;

   always_comb begin
      row       = cmd_ff.y + fbre_pkg::CW'(r_ff);
      col       = cmd_ff.x + fbre_pkg::CW'(c_ff);
      cell_addr = AW'(row * MAX_COLS + col);
      in_act    = (row < fbre_pkg::CW'(cmd_ff.act_rows)) &&
                  (col < fbre_pkg::CW'(cmd_ff.act_cols));
      row_edge  = (r_ff == '0) || (r_ff == cmd_ff.h - fbre_pkg::SW'(1));
      col_last  = (c_ff == cmd_ff.w - fbre_pkg::SW'(1));
      fill      = (cmd_ff.op != fbre_pkg::REQ_OUTLINE);
      // border cells always count; interior cells only when filling
      touch     = row_edge || (c_ff == '0) || col_last || fill;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbre_pkg::ST_INIT;
         init_ff  <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      clip_ff <= clip_in;
      hit_ff  <= hit_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      clip_in       = clip_ff;
      hit_in        = hit_ff;
      init_in       = init_ff;
      cmd_ready     = 1'b0;
      rsp.valid     = 1'b0;
      rsp.cell_char = '0;
      rsp.status    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = cell_addr;
      wr_data       = cmd_ff.inner;
      rd_en         = 1'b0;
      rd_addr       = cell_addr;

      unique case (state_ff)
         fbre_pkg::ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_ff;
            wr_data = fbre_pkg::SPACE_CHAR;
            init_in = init_ff + AW'(1);
            if (init_ff == LAST) begin
               state_in = fbre_pkg::ST_IDLE;
            end
         end

         fbre_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in  = cmd;
               r_in    = '0;
               c_in    = '0;
               clip_in = 1'b0;
               hit_in  = 1'b0;
               unique case (cmd.op)
                  fbre_pkg::REQ_SET, fbre_pkg::REQ_CLEAR,
                  fbre_pkg::REQ_OUTLINE, fbre_pkg::REQ_FILL: begin
                     if (cmd.w == '0 || cmd.h == '0) begin
                        state_in = fbre_pkg::ST_DONE;
                     end else begin
                        state_in = fbre_pkg::ST_WALK;
                     end
                  end
                  fbre_pkg::REQ_READ: state_in = fbre_pkg::ST_READ;
                  default:            state_in = fbre_pkg::ST_DONE;
               endcase
            end
         end

         fbre_pkg::ST_WALK: begin
            wr_en   = in_act && touch;
            wr_data = (row_edge || c_ff == '0 || col_last) ? cmd_ff.border : cmd_ff.inner;
            clip_in = clip_ff || (!in_act && touch);
            priority if (col_last) begin
               c_in = '0;
               if (r_ff == cmd_ff.h - fbre_pkg::SW'(1)) begin
                  state_in = fbre_pkg::ST_DONE;
               end else begin
                  r_in = r_ff + fbre_pkg::SW'(1);
               end
            end else if (!fill && !row_edge && c_ff == '0) begin
               // jump over the interior of an outline row
               c_in = cmd_ff.w - fbre_pkg::SW'(1);
            end else begin
               c_in = c_ff + fbre_pkg::SW'(1);
            end
         end

         fbre_pkg::ST_READ: begin
            rd_en    = in_act;
            hit_in   = in_act;
            clip_in  = !in_act;
            state_in = fbre_pkg::ST_DONE;
         end

         fbre_pkg::ST_DONE: begin
            rsp.valid     = 1'b1;
            rsp.cell_char = hit_ff ? rd_data : 8'h00;
            rsp.status    = clip_ff;
            if (rsp_free) begin
               state_in = fbre_pkg::ST_IDLE;
            end
         end

         default: state_in = fbre_pkg::ST_IDLE;
      endcase
   end

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store written and read in one cycle");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbre_pkg::ST_READ |=> state_ff == fbre_pkg::ST_DONE)
      else $error("read did not finish in one cycle");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbre_pkg::ST_WALK |-> (r_ff < cmd_ff.h) && (c_ff < cmd_ff.w))
      else $error("walk counter past rectangle");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_addr <= LAST)
      else $error("write address outside store");

endmodule

>>> rtl/core/char_framebuffer_rect_engine_unit.sv
`timescale 1ns / 1ps
// channel | ports                                   | direction
// req     | req_valid, req_stall, req_type .. level | in, stall out
// rsp     | rsp_valid, rsp_stall, rsp_cell_char/st. | out, stall in
// csr     | csr_valid, csr_ready, csr_index, data   | in, ready out
//
// Set and read touch one cell, clear walks the rows*cols active area, fill the w*h
// rectangle, outline only its border cells (all cells when w or h is 1), and a
// zero size or unused type none; the single write port of the cell store paces the walk.
// After reset a clearing pass writes spaces to all MAX_ROWS*MAX_COLS cells, one
// per cycle, and takes no item meanwhile; csr writes are taken at any time.
// A finished item waits in the rsp register while the next item is accepted;
// while rsp_stall holds a full rsp register, the next finished item waits too.
module char_framebuffer_rect_engine_unit #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_x,
   input  logic [4:0]  req_y,
   input  logic [6:0]  req_width,
   input  logic [5:0]  req_height,
   input  logic [3:0]  req_line_level,
   input  logic [3:0]  req_fill_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_cell_char,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [5:0]  rows_ff;
   logic [6:0]  cols_ff;
   logic [63:0] sym_lo_ff;
   logic [63:0] sym_hi_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_char_ff;
   logic        rsp_status_ff;

   logic [fbre_pkg::SW-1:0] act_rows;
   logic [fbre_pkg::SW-1:0] act_cols;
   logic [7:0]              line_ch;
   logic [7:0]              fill_ch;
   fbre_pkg::cmd_type       cmd;
   fbre_pkg::rsp_type       rsp;
   logic                    cmd_ready;
   logic                    rsp_free;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= 6'd32;
         cols_ff   <= 7'd64;
         sym_lo_ff <= '0;
         sym_hi_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            fbre_pkg::CSR_ROWS:   rows_ff   <= csr_data[5:0];
            fbre_pkg::CSR_COLS:   cols_ff   <= csr_data[6:0];
            fbre_pkg::CSR_SYM_LO: sym_lo_ff <= csr_data;
            fbre_pkg::CSR_SYM_HI: sym_hi_ff <= csr_data;
         endcase
      end
   end

   always_comb begin
      act_rows = (rows_ff > MAX_ROWS) ? fbre_pkg::SW'(MAX_ROWS) : fbre_pkg::SW'(rows_ff);
      act_cols = (cols_ff > MAX_COLS) ? fbre_pkg::SW'(MAX_COLS) : fbre_pkg::SW'(cols_ff);
      line_ch  = fbre_pkg::level_char(sym_lo_ff, sym_hi_ff, req_line_level);
      fill_ch  = fbre_pkg::level_char(sym_lo_ff, sym_hi_ff, req_fill_level);

      cmd.op       = req_type;
      cmd.x        = fbre_pkg::CW'(req_x);
      cmd.y        = fbre_pkg::CW'(req_y);
      cmd.w        = fbre_pkg::SW'(req_width);
      cmd.h        = fbre_pkg::SW'(req_height);
      cmd.border   = line_ch;
      cmd.inner    = fill_ch;
      cmd.act_rows = act_rows;
      cmd.act_cols = act_cols;
      // a single cell and a full clear run through the rectangle walk
      if (req_type == fbre_pkg::REQ_SET) begin
         cmd.w = fbre_pkg::SW'(1);
         cmd.h = fbre_pkg::SW'(1);
      end else if (req_type == fbre_pkg::REQ_CLEAR) begin
         cmd.x     = '0;
         cmd.y     = '0;
         cmd.w     = act_cols;
         cmd.h     = act_rows;
         cmd.inner = line_ch;
      end
   end

   assign req_stall = !cmd_ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp.valid && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.valid && rsp_free) begin
         rsp_char_ff   <= rsp.cell_char;
         rsp_status_ff <= rsp.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_char = rsp_char_ff;
   assign rsp_status    = rsp_status_ff;

   fbre_seq #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS),
      .AW(AW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .cmd_valid(req_valid),
      .cmd_ready(cmd_ready),
      .rsp_free(rsp_free),
      .rsp(rsp),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr)
   );

   fbre_store #(
      .DEPTH(DEPTH),
      .AW(AW)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;

   localparam int GRID_ROWS = 32;
   localparam int GRID_COLS = 64;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 50;
   localparam longint RUN_LIMIT_NS = 64'd12_000_000 * 8;
   // request types the block leaves alone
   localparam logic [2:0] REQ_SPARE_LO = 3'd5;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0] kind;
      logic [5:0] col;
      logic [4:0] row;
      logic [6:0] wd;
      logic [5:0] ht;
      logic [3:0] line_lv;
      logic [3:0] fill_lv;
   } draw_req_type;

   typedef struct {
      logic [7:0] ch;
      logic       st;
   } draw_rsp_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = '0;
   logic [5:0]  req_x = '0;
   logic [4:0]  req_y = '0;
   logic [6:0]  req_width = '0;
   logic [5:0]  req_height = '0;
   logic [3:0]  req_line_level = '0;
   logic [3:0]  req_fill_level = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_cell_char;
   logic        rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   char_framebuffer_rect_engine_unit #(
      .MAX_ROWS(GRID_ROWS),
      .MAX_COLS(GRID_COLS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_x(req_x),
      .req_y(req_y),
      .req_width(req_width),
      .req_height(req_height),
      .req_line_level(req_line_level),
      .req_fill_level(req_fill_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cell_char(rsp_cell_char),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow of the screen and its settings
   logic [7:0]  shadow_cells [0:GRID_ROWS*GRID_COLS-1];
   logic [5:0]  cfg_rows;
   logic [6:0]  cfg_cols;
   logic [63:0] cfg_sym_lo;
   logic [63:0] cfg_sym_hi;

   draw_req_type draw_cmd_q [$];
   draw_rsp_type cell_result_q [$];
   draw_req_type cur_req;
   int error_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int long_hold_req = 0;
   int long_hold_done = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

   function automatic int act_rows();
      return (cfg_rows > GRID_ROWS) ? GRID_ROWS : int'(cfg_rows);
   endfunction

   function automatic int act_cols();
      return (cfg_cols > GRID_COLS) ? GRID_COLS : int'(cfg_cols);
   endfunction

   function automatic logic [7:0] sym_of(input logic [3:0] lv);
      logic [63:0] word;
      word = lv[3] ? cfg_sym_hi : cfg_sym_lo;
      return 8'(word >> (8 * lv[2:0]));
   endfunction

   // write one cell if it is on screen; return 1 when clipped
   function automatic logic paint(input int r, input int c, input logic [7:0] ch);
      if (r >= act_rows() || c >= act_cols())
         return 1'b1;
      shadow_cells[r*GRID_COLS + c] = ch;
      return 1'b0;
   endfunction

   function automatic draw_rsp_type frame_apply(input draw_req_type q);
      draw_rsp_type res;
      logic [7:0] line_ch;
      logic [7:0] fill_ch;
      logic border_cell;
      res.ch = 8'h00;
      res.st = 1'b0;
      line_ch = sym_of(q.line_lv);
      fill_ch = sym_of(q.fill_lv);
      case (q.kind)
         fbre_pkg::REQ_SET: begin
            res.st = paint(q.row, q.col, line_ch);
         end
         fbre_pkg::REQ_CLEAR: begin
            for (int r = 0; r < act_rows(); r++)
               for (int c = 0; c < act_cols(); c++)
                  shadow_cells[r*GRID_COLS + c] = line_ch;
         end
         fbre_pkg::REQ_OUTLINE, fbre_pkg::REQ_FILL: begin
            if (q.wd != 0 && q.ht != 0) begin
               for (int r = 0; r < int'(q.ht); r++) begin
                  for (int c = 0; c < int'(q.wd); c++) begin
                     border_cell = (r == 0) || (c == 0) || (r == int'(q.ht) - 1) ||
                                   (c == int'(q.wd) - 1);
                     if (border_cell) begin
                        if (paint(q.row + r, q.col + c, line_ch)) res.st = 1'b1;
                     end else if (q.kind == fbre_pkg::REQ_FILL) begin
                        if (paint(q.row + r, q.col + c, fill_ch)) res.st = 1'b1;
                     end
                  end
               end
            end
         end
         fbre_pkg::REQ_READ: begin
            if (q.row < act_rows() && q.col < act_cols())
               res.ch = shadow_cells[q.row*GRID_COLS + q.col];
            else
               res.st = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void flag_error(input string what);
      error_count++;
      if (error_count <= 10)
         $display("ERROR at %0t ns: %s", $time, what);
   endfunction

   // sender: bursts of items separated by random gaps
   always @(posedge clock) begin : req_driver
      draw_rsp_type pred;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pred = frame_apply(cur_req);
            cell_result_q.push_back(pred);
         end
         // hold a stalled item as it is
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (draw_cmd_q.size() != 0) begin
               cur_req = draw_cmd_q.pop_front();
               req_type <= cur_req.kind;
               req_x <= cur_req.col;
               req_y <= cur_req.row;
               req_width <= cur_req.wd;
               req_height <= cur_req.ht;
               req_line_level <= cur_req.line_lv;
               req_fill_level <= cur_req.fill_lv;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (long_hold_done < long_hold_req) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 80);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      draw_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cell_result_q.size() == 0) begin
            flag_error($sformatf("unexpected item: cell_char %02h status %0d",
                                 rsp_cell_char, rsp_status));
         end else begin
            want = cell_result_q.pop_front();
            if (rsp_cell_char !== want.ch)
               flag_error($sformatf("cell_char expected %02h got %02h",
                                    want.ch, rsp_cell_char));
            if (rsp_status !== want.st)
               flag_error($sformatf("status expected %0d got %0d", want.st, rsp_status));
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         fbre_pkg::CSR_ROWS:   cfg_rows = val[5:0];
         fbre_pkg::CSR_COLS:   cfg_cols = val[6:0];
         fbre_pkg::CSR_SYM_LO: cfg_sym_lo = val;
         fbre_pkg::CSR_SYM_HI: cfg_sym_hi = val;
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int r, input int c);
      csr_write(fbre_pkg::CSR_ROWS, 64'(r));
      csr_write(fbre_pkg::CSR_COLS, 64'(c));
   endtask

   task automatic push_req(input logic [2:0] k, input int c, input int r, input int w,
                           input int h, input int ll, input int fl);
      draw_req_type q;
      q.kind = k;
      q.col = 6'(c);
      q.row = 5'(r);
      q.wd = 7'(w);
      q.ht = 6'(h);
      q.line_lv = 4'(ll);
      q.fill_lv = 4'(fl);
      draw_cmd_q.push_back(q);
   endtask

   // wait until every item has been taken and answered
   task automatic wait_idle();
      do @(negedge clock);
      while (draw_cmd_q.size() != 0 || req_valid || cell_result_q.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic draw_req_type rand_item();
      draw_req_type q;
      int pick;
      int sz;
      pick = $urandom_range(0, 99);
      if (pick < 25)      q.kind = fbre_pkg::REQ_SET;
      else if (pick < 45) q.kind = fbre_pkg::REQ_READ;
      else if (pick < 62) q.kind = fbre_pkg::REQ_OUTLINE;
      else if (pick < 82) q.kind = fbre_pkg::REQ_FILL;
      else if (pick < 88) q.kind = fbre_pkg::REQ_CLEAR;
      else if (pick < 93) q.kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      else                q.kind = fbre_pkg::REQ_SET;
      // mostly on screen, sometimes anywhere
      if ($urandom_range(0, 4) != 0 && act_cols() > 0)
         q.col = 6'($urandom_range(0, act_cols() - 1));
      else
         q.col = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 4) != 0 && act_rows() > 0)
         q.row = 5'($urandom_range(0, act_rows() - 1));
      else
         q.row = 5'($urandom_range(0, 31));
      sz = $urandom_range(0, 99);
      if (sz < 88) begin
         q.wd = 7'($urandom_range(0, 8));
         q.ht = 6'($urandom_range(0, 6));
      end else if (sz < 97) begin
         q.wd = 7'($urandom_range(0, 24));
         q.ht = 6'($urandom_range(0, 12));
      end else begin
         q.wd = 7'($urandom_range(0, 127));
         q.ht = 6'($urandom_range(0, 63));
      end
      q.line_lv = 4'($urandom_range(0, 15));
      q.fill_lv = 4'($urandom_range(0, 15));
      return q;
   endfunction

   task automatic run_phase(input int n);
      draw_req_type q;
      int made;
      made = 0;
      @(negedge clock);
      while (made < n) begin
         q = rand_item();
         draw_cmd_q.push_back(q);
         made++;
         // read back what was just drawn
         if (q.kind == fbre_pkg::REQ_SET && $urandom_range(0, 2) == 0) begin
            push_req(fbre_pkg::REQ_READ, q.col, q.row, 0, 0, 0, 0);
            made++;
         end else if (q.kind == fbre_pkg::REQ_FILL && q.wd > 2 && q.ht > 2 &&
                      $urandom_range(0, 2) == 0) begin
            push_req(fbre_pkg::REQ_READ, q.col + 1, q.row + 1, 0, 0, 0, 0);
            made++;
         end
      end
      wait_idle();
   endtask

   initial begin : stimulus
      for (int i = 0; i < GRID_ROWS*GRID_COLS; i++)
         shadow_cells[i] = fbre_pkg::SPACE_CHAR;
      cfg_rows = 6'd32;
      cfg_cols = 7'd64;
      cfg_sym_lo = '0;
      cfg_sym_hi = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // distinct characters per level
      csr_write(fbre_pkg::CSR_SYM_LO, 64'h3f_2e_2b_2a_23_40_3d_41);
      csr_write(fbre_pkg::CSR_SYM_HI, 64'hff_80_7e_5a_4f_58_2d_7c);
      @(negedge clock);
      push_req(fbre_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
      push_req(fbre_pkg::REQ_SET, 0, 0, 0, 0, 15, 0);
      push_req(fbre_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
      push_req(fbre_pkg::REQ_SET, 63, 31, 0, 0, 0, 15);
      push_req(fbre_pkg::REQ_READ, 63, 31, 0, 0, 0, 0);
      push_req(fbre_pkg::REQ_OUTLINE, 2, 2, 5, 4, 3, 9);
      push_req(fbre_pkg::REQ_READ, 3, 3, 0, 0, 0, 0);
      push_req(fbre_pkg::REQ_READ, 2, 2, 0, 0, 0, 0);
      push_req(fbre_pkg::REQ_FILL, 10, 5, 4, 3, 1, 2);
      push_req(fbre_pkg::REQ_READ, 11, 6, 0, 0, 0, 0);
      push_req(fbre_pkg::REQ_FILL, 4, 4, 0, 5, 6, 7);
      push_req(fbre_pkg::REQ_OUTLINE, 4, 4, 3, 0, 6, 7);
      push_req(fbre_pkg::REQ_FILL, 20, 10, 1, 6, 8, 12);
      push_req(fbre_pkg::REQ_FILL, 30, 12, 5, 1, 4, 13);
      push_req(fbre_pkg::REQ_FILL, 60, 28, 10, 10, 11, 14);
      push_req(fbre_pkg::REQ_OUTLINE, 62, 30, 4, 4, 5, 6);
      push_req(fbre_pkg::REQ_FILL, 0, 0, 127, 63, 5, 10);
      push_req(fbre_pkg::REQ_READ, 40, 20, 0, 0, 0, 0);
      push_req(fbre_pkg::REQ_CLEAR, 17, 9, 3, 3, 7, 2);
      push_req(fbre_pkg::REQ_READ, 5, 5, 0, 0, 0, 0);
      push_req(REQ_SPARE_HI, 63, 31, 127, 63, 15, 15);
      push_req(REQ_SPARE_LO, 0, 0, 0, 0, 0, 0);
      push_req(fbre_pkg::REQ_OUTLINE, 0, 0, 64, 32, 12, 3);
      push_req(fbre_pkg::REQ_READ, 1, 1, 0, 0, 0, 0);
      wait_idle();

      // nothing on screen
      set_geometry(0, 0);
      run_phase(20);
      // oversized geometry acts as the full store
      csr_write(fbre_pkg::CSR_SYM_LO, '1);
      csr_write(fbre_pkg::CSR_SYM_HI, '0);
      set_geometry(63, 127);
      run_phase(36);
      csr_write(fbre_pkg::CSR_SYM_LO, {$urandom, $urandom});
      csr_write(fbre_pkg::CSR_SYM_HI, {$urandom, $urandom});
      set_geometry(1, 1);
      run_phase(24);
      // full screen while the receiver holds off for a long stretch
      set_geometry(32, 64);
      csr_write(fbre_pkg::CSR_SYM_HI, {$urandom, $urandom});
      @(negedge clock);
      long_hold_req++;
      run_phase(60);
      repeat (4) begin
         csr_write(fbre_pkg::CSR_SYM_LO, {$urandom, $urandom});
         csr_write(fbre_pkg::CSR_SYM_HI, {$urandom, $urandom});
         set_geometry($urandom_range(1, 32), $urandom_range(1, 64));
         run_phase(32);
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (cell_result_q.size() != 0)
         flag_error($sformatf("%0d items never came back", cell_result_q.size()));
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
